/* rtl/tslc_pkg.sv */
// Shared types and constants for the triangle strain limit checker.
package tslc_pkg;

    localparam int POS_W  = 24;
    localparam int INV_W  = 32;
    localparam int MOD_W  = 32;
    localparam int DIFF_W = 25;
    localparam int F_W    = 29;
    localparam int E_W    = 32;
    localparam int BASE_W = 17;
    localparam int SEV_W  = 17;
    localparam int SCL_W  = 18;
    localparam int ROOT_W = 32;
    localparam int SEVQ_W = 16;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic signed [50:0] DET_EPS   = 51'sd10995116;
    localparam logic [MOD_W-1:0]   RIGID_MOD = 32'd4096000000;
    localparam logic [SCL_W-1:0]   SCALE_MIN = 18'd9830;
    localparam logic [SCL_W-1:0]   SCALE_MAX = 18'd196608;
    localparam logic [SEV_W-1:0]   LIMIT_MIN = 17'd328;
    localparam logic [SEV_W-1:0]   LIMIT_MAX = 17'd65536;
    localparam logic [SEV_W-1:0]   SEV_FULL  = 17'd65536;
    localparam logic [BASE_W-1:0]  BASE_RST  = 17'd55706;
    localparam logic [MOD_W-1:0]   REF_RST   = 32'd860160;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_REF  = 1'b1;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic signed [F_W-1:0] f00;
        logic signed [F_W-1:0] f01;
        logic signed [F_W-1:0] f10;
        logic signed [F_W-1:0] f11;
        logic                  degenerate;
        logic [MOD_W-1:0]      modulus;
    } tslc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tslc_qstat_t;

endpackage

/* rtl/tslc_front.sv */
// Front: accepts items, forms the deformation gradient and the degenerate flag.
module tslc_front
    import tslc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] origin_x,
    input  logic signed [POS_W-1:0] origin_y,
    input  logic signed [POS_W-1:0] first_x,
    input  logic signed [POS_W-1:0] first_y,
    input  logic signed [POS_W-1:0] second_x,
    input  logic signed [POS_W-1:0] second_y,
    input  logic signed [INV_W-1:0] rest_inv_a,
    input  logic signed [INV_W-1:0] rest_inv_b,
    input  logic signed [INV_W-1:0] rest_inv_c,
    input  logic signed [INV_W-1:0] rest_inv_d,
    input  logic [MOD_W-1:0]        material_modulus,
    input  tslc_qstat_t             qstat,
    output logic                    push,
    output tslc_item_t              push_item
);

    function automatic logic signed [F_W-1:0] round_sat_f(input logic signed [57:0] x);
        logic signed [57:0] r;
        r = (x + 58'sd524288) >>> 20;
        if (r > 58'sd268435455)
            return 29'sd268435455;
        else if (r < -58'sd268435455)
            return -29'sd268435455;
        else
            return r[F_W-1:0];
    endfunction

    logic adv;
    logic vld_a_reg, vld_b_reg, vld_c_reg;

    logic signed [DIFF_W-1:0] d00_reg, d01_reg, d10_reg, d11_reg;
    logic signed [INV_W-1:0]  ia_reg, ib_reg, ic_reg, id_reg;
    logic [MOD_W-1:0]         mod_a_reg, mod_b_reg;
    logic signed [49:0]       pdet0_reg, pdet1_reg;
    logic signed [56:0]       pr_reg [0:7];
    logic signed [50:0]       det;
    tslc_item_t               item_reg;

    // stall only when the last stage holds an item and the queue has no room
    assign adv      = !(vld_c_reg && qstat.full);
    assign in_ready = adv;
    assign push     = vld_c_reg && adv;
    assign push_item = item_reg;

    assign det = 51'(pdet0_reg) - 51'(pdet1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d00_reg   <= DIFF_W'(first_x) - DIFF_W'(origin_x);
            d10_reg   <= DIFF_W'(first_y) - DIFF_W'(origin_y);
            d01_reg   <= DIFF_W'(second_x) - DIFF_W'(origin_x);
            d11_reg   <= DIFF_W'(second_y) - DIFF_W'(origin_y);
            ia_reg    <= rest_inv_a;
            ib_reg    <= rest_inv_b;
            ic_reg    <= rest_inv_c;
            id_reg    <= rest_inv_d;
            mod_a_reg <= material_modulus;

            pdet0_reg <= 50'(d00_reg * d11_reg);
            pdet1_reg <= 50'(d01_reg * d10_reg);
            pr_reg[0] <= 57'(d00_reg * ia_reg);
            pr_reg[1] <= 57'(d01_reg * ic_reg);
            pr_reg[2] <= 57'(d00_reg * ib_reg);
            pr_reg[3] <= 57'(d01_reg * id_reg);
            pr_reg[4] <= 57'(d10_reg * ia_reg);
            pr_reg[5] <= 57'(d11_reg * ic_reg);
            pr_reg[6] <= 57'(d10_reg * ib_reg);
            pr_reg[7] <= 57'(d11_reg * id_reg);
            mod_b_reg <= mod_a_reg;

            item_reg.f00        <= round_sat_f(58'(pr_reg[0]) + 58'(pr_reg[1]));
            item_reg.f01        <= round_sat_f(58'(pr_reg[2]) + 58'(pr_reg[3]));
            item_reg.f10        <= round_sat_f(58'(pr_reg[4]) + 58'(pr_reg[5]));
            item_reg.f11        <= round_sat_f(58'(pr_reg[6]) + 58'(pr_reg[7]));
            item_reg.degenerate <= (det <= DET_EPS);
            item_reg.modulus    <= mod_b_reg;
        end
    end

endmodule

/* rtl/tslc_queue.sv */
// Short queue between the front and the back.
module tslc_queue
    import tslc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  tslc_item_t  push_item,
    input  logic        pop,
    output tslc_item_t  pop_item,
    output tslc_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tslc_item_t          mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_item    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/tslc_back.sv */
// Back: Green strain, norm square root, strain limit and severity division.
module tslc_back
    import tslc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tslc_qstat_t        qstat,
    input  tslc_item_t         q_item,
    output logic               pop,
    input  logic [BASE_W-1:0]  base_strain_limit,
    input  logic [MOD_W-1:0]   reference_modulus,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SEV_W-1:0]   severity,
    output logic               allowed,
    output logic               degenerate
);

    function automatic logic signed [E_W-1:0] round_sat_e(input logic signed [58:0] x);
        logic signed [58:0] r;
        r = (x + 59'sd16777216) >>> 25;
        if (r > 59'sd2147483647)
            return 32'sd2147483647;
        else if (r < -59'sd2147483647)
            return -32'sd2147483647;
        else
            return r[E_W-1:0];
    endfunction

    logic adv;

    // early stages
    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    tslc_item_t         it0_reg;
    logic signed [56:0] cp_reg [0:5];
    logic signed [E_W-1:0] e00_reg, e01_reg, e11_reg;
    logic [63:0]        sq0_reg, sq1_reg, sq2_reg;
    logic               dg1_reg, dg2_reg, dg3_reg;
    logic [MOD_W-1:0]   md1_reg, md2_reg, md3_reg;
    logic [MOD_W-1:0]   stiff3;

    // root and scale divider pipeline
    logic [63:0]        srem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]  root_reg  [0:ROOT_W];
    logic [49:0]        drem_reg  [0:ROOT_W];
    logic [SCL_W-1:0]   dq_reg    [0:ROOT_W];
    logic [MOD_W-1:0]   stiff_reg [0:ROOT_W];
    logic               sat_reg   [0:ROOT_W];
    logic               dgs_reg   [0:ROOT_W];
    logic               vs_reg    [0:ROOT_W];

    // limit stages
    logic               v5_reg, v6_reg;
    logic [34:0]        prod_reg;
    logic [ROOT_W-1:0]  norm5_reg, norm6_reg;
    logic               dg5_reg, dg6_reg;
    logic [SEV_W-1:0]   limit_reg;
    logic [SCL_W-1:0]   scale_next;
    logic [18:0]        lim_raw;
    logic [SEV_W-1:0]   limit_next;

    // severity divider pipeline
    logic [ROOT_W:0]    vrem_reg  [0:SEVQ_W];
    logic [SEVQ_W-1:0]  vq_reg    [0:SEVQ_W];
    logic [ROOT_W-1:0]  vnorm_reg [0:SEVQ_W];
    logic               vover_reg [0:SEVQ_W];
    logic               vdg_reg   [0:SEVQ_W];
    logic               vv_reg    [0:SEVQ_W];

    logic               out_valid_reg;
    logic [SEV_W-1:0]   sev_reg;
    logic               allowed_reg, degenerate_reg;

    assign adv        = !out_valid_reg || out_ready;
    assign pop        = adv && !qstat.empty;
    assign out_valid  = out_valid_reg;
    assign severity   = sev_reg;
    assign allowed    = allowed_reg;
    assign degenerate = degenerate_reg;

    assign stiff3 = (md3_reg == '0) ? RIGID_MOD : md3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vs_reg[0] <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vv_reg[0] <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= !qstat.empty;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vs_reg[0] <= v3_reg;
            v5_reg <= vs_reg[ROOT_W];
            v6_reg <= v5_reg;
            vv_reg[0] <= v6_reg;
            out_valid_reg <= vv_reg[SEVQ_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it0_reg <= q_item;

            cp_reg[0] <= 57'(it0_reg.f00 * it0_reg.f00);
            cp_reg[1] <= 57'(it0_reg.f10 * it0_reg.f10);
            cp_reg[2] <= 57'(it0_reg.f00 * it0_reg.f01);
            cp_reg[3] <= 57'(it0_reg.f10 * it0_reg.f11);
            cp_reg[4] <= 57'(it0_reg.f01 * it0_reg.f01);
            cp_reg[5] <= 57'(it0_reg.f11 * it0_reg.f11);
            dg1_reg   <= it0_reg.degenerate;
            md1_reg   <= it0_reg.modulus;

            // (C - I) / 2 down to Q.16
            e00_reg <= round_sat_e(59'(cp_reg[0]) + 59'(cp_reg[1]) - 59'sd1099511627776);
            e01_reg <= round_sat_e(59'(cp_reg[2]) + 59'(cp_reg[3]));
            e11_reg <= round_sat_e(59'(cp_reg[4]) + 59'(cp_reg[5]) - 59'sd1099511627776);
            dg2_reg <= dg1_reg;
            md2_reg <= md1_reg;

            sq0_reg <= 64'(e00_reg * e00_reg);
            sq1_reg <= 64'(e01_reg * e01_reg);
            sq2_reg <= 64'(e11_reg * e11_reg);
            dg3_reg <= dg2_reg;
            md3_reg <= md2_reg;

            srem_reg[0]  <= sq0_reg + {sq1_reg[62:0], 1'b0} + sq2_reg;
            root_reg[0]  <= '0;
            drem_reg[0]  <= {2'b00, reference_modulus, 16'h0000};
            dq_reg[0]    <= '0;
            stiff_reg[0] <= stiff3;
            // quotient at or above 2^18 is past the clamp anyway
            sat_reg[0]   <= ({2'b00, reference_modulus, 16'h0000} >= {stiff3, 18'h00000});
            dgs_reg[0]   <= dg3_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_root
            localparam int RB = ROOT_W - 1 - k;
            logic [65:0] trial;
            logic        take;
            assign trial = ({34'b0, root_reg[k]} << (RB + 1)) + (66'd1 << (2 * RB));
            assign take  = ({2'b00, srem_reg[k]} >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn)
                    vs_reg[k+1] <= 1'b0;
                else if (adv)
                    vs_reg[k+1] <= vs_reg[k];
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    srem_reg[k+1]  <= take ? srem_reg[k] - trial[63:0] : srem_reg[k];
                    root_reg[k+1]  <= take ? (root_reg[k] | (ROOT_W'(1) << RB)) : root_reg[k];
                    stiff_reg[k+1] <= stiff_reg[k];
                    sat_reg[k+1]   <= sat_reg[k];
                    dgs_reg[k+1]   <= dgs_reg[k];
                end
            end

            if (k < SCL_W) begin : g_div
                localparam int DB = SCL_W - 1 - k;
                logic [49:0] dsub;
                logic        dtake;
                assign dsub  = {18'b0, stiff_reg[k]} << DB;
                assign dtake = (drem_reg[k] >= dsub);
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        drem_reg[k+1] <= dtake ? drem_reg[k] - dsub : drem_reg[k];
                        dq_reg[k+1]   <= dtake ? (dq_reg[k] | (SCL_W'(1) << DB)) : dq_reg[k];
                    end
                end
            end else begin : g_pass
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        drem_reg[k+1] <= drem_reg[k];
                        dq_reg[k+1]   <= dq_reg[k];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        if (sat_reg[ROOT_W] || dq_reg[ROOT_W] > SCALE_MAX)
            scale_next = SCALE_MAX;
        else if (dq_reg[ROOT_W] < SCALE_MIN)
            scale_next = SCALE_MIN;
        else
            scale_next = dq_reg[ROOT_W];
        lim_raw = 19'((prod_reg + 35'd32768) >> 16);
        if (lim_raw < 19'(LIMIT_MIN))
            limit_next = LIMIT_MIN;
        else if (lim_raw > 19'(LIMIT_MAX))
            limit_next = LIMIT_MAX;
        else
            limit_next = lim_raw[SEV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= 35'(base_strain_limit * scale_next);
            norm5_reg <= root_reg[ROOT_W];
            dg5_reg   <= dgs_reg[ROOT_W];

            limit_reg <= limit_next;
            norm6_reg <= norm5_reg;
            dg6_reg   <= dg5_reg;

            vover_reg[0] <= (norm6_reg > ROOT_W'(limit_reg));
            vrem_reg[0]  <= {1'b0, norm6_reg} - (ROOT_W + 1)'(limit_reg);
            vq_reg[0]    <= '0;
            vnorm_reg[0] <= norm6_reg;
            vdg_reg[0]   <= dg6_reg;
        end
    end

    genvar m;
    generate
        for (m = 0; m < SEVQ_W; m++) begin : g_sev
            localparam int SB = SEVQ_W - 1 - m;
            logic [ROOT_W+1:0] shifted;
            logic              stake;
            assign shifted = {vrem_reg[m], 1'b0};
            assign stake   = (shifted >= {2'b00, vnorm_reg[m]});

            always_ff @(posedge aclk) begin
                if (!aresetn)
                    vv_reg[m+1] <= 1'b0;
                else if (adv)
                    vv_reg[m+1] <= vv_reg[m];
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    vrem_reg[m+1]  <= stake ? 33'(shifted - {2'b00, vnorm_reg[m]})
                                            : shifted[ROOT_W:0];
                    vq_reg[m+1]    <= stake ? (vq_reg[m] | (SEVQ_W'(1) << SB)) : vq_reg[m];
                    vnorm_reg[m+1] <= vnorm_reg[m];
                    vover_reg[m+1] <= vover_reg[m];
                    vdg_reg[m+1]   <= vdg_reg[m];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (vdg_reg[SEVQ_W]) begin
                sev_reg        <= SEV_FULL;
                allowed_reg    <= 1'b0;
                degenerate_reg <= 1'b1;
            end else if (vover_reg[SEVQ_W]) begin
                sev_reg        <= {1'b0, vq_reg[SEVQ_W]};
                allowed_reg    <= 1'b0;
                degenerate_reg <= 1'b0;
            end else begin
                sev_reg        <= '0;
                allowed_reg    <= 1'b1;
                degenerate_reg <= 1'b0;
            end
        end
    end

    a_allowed_no_sev: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && allowed_reg |-> sev_reg == '0)
        else $error("allowed item with nonzero severity");

    a_degen_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && degenerate_reg |-> sev_reg == SEV_FULL && !allowed_reg)
        else $error("degenerate item without full severity");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

/* rtl/triangle_strain_limit_check_unit.sv */
// Top level of the triangle strain limit checker.
// Takes one triangle item per cycle while m_tready stays high and returns one result item per
// triangle, in order. Items pass through the front, the queue and the back; in the back, the
// 32-step square root pipeline (which also carries the 18-step strain scale divider) is followed
// by the strain limit stages and the 16-step severity divider. The queue lets the front keep
// accepting briefly while the back stalls.
module triangle_strain_limit_check_unit
    import tslc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, first_x, first_y, second_x, second_y, rest_inv_a,
    // rest_inv_b, rest_inv_c, rest_inv_d, material_modulus
    input  logic [303:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // severity, allowed, degenerate, zero fill
    output logic [23:0]  m_tdata
);

    logic [BASE_W-1:0] base_reg;
    logic [MOD_W-1:0]  ref_reg;
    logic              push, pop;
    tslc_item_t        push_item, pop_item;
    tslc_qstat_t       qstat;
    logic [SEV_W-1:0]  severity;
    logic              allowed, degenerate;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RST;
            ref_reg  <= REF_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BASE: base_reg <= cfg_data[BASE_W-1:0];
                CFG_REF:  ref_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    tslc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .origin_x         (s_tdata[23:0]),
        .origin_y         (s_tdata[47:24]),
        .first_x          (s_tdata[71:48]),
        .first_y          (s_tdata[95:72]),
        .second_x         (s_tdata[119:96]),
        .second_y         (s_tdata[143:120]),
        .rest_inv_a       (s_tdata[175:144]),
        .rest_inv_b       (s_tdata[207:176]),
        .rest_inv_c       (s_tdata[239:208]),
        .rest_inv_d       (s_tdata[271:240]),
        .material_modulus (s_tdata[303:272]),
        .qstat            (qstat),
        .push             (push),
        .push_item        (push_item)
    );

    tslc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    tslc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .qstat             (qstat),
        .q_item            (pop_item),
        .pop               (pop),
        .base_strain_limit (base_reg),
        .reference_modulus (ref_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .severity          (severity),
        .allowed           (allowed),
        .degenerate        (degenerate)
    );

    assign m_tdata = {5'b00000, degenerate, allowed, severity};

endmodule
